// ===== rtl/assert_macros.svh =====
// Assertion macros, included by min_heap_timer_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mhtq_pkg.sv =====
package mhtq_pkg;

    localparam int ID_W     = 10;
    localparam int TMO_W    = 24;
    localparam int KIND_W   = 3;
    localparam int RKIND_W  = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADJUST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd5;

    localparam logic [RKIND_W-1:0] RES_ACK    = 2'd0;
    localparam logic [RKIND_W-1:0] RES_FIRED  = 2'd1;
    localparam logic [RKIND_W-1:0] RES_REPORT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic [TMO_W-1:0] REM_MAX = '1;

endpackage

// ===== rtl/min_heap_timer_queue.sv =====
// Timer queue: a binary min-heap of timers ordered by expiry, with an id to slot table.
// Input channel: in_valid/in_stall carry one word of kind, timer_id and timeout_ms.
// Output channel: out_valid/out_stall carry result words; last marks the final word
// caused by an input word. Undefined kinds are taken and give no result.
// After reset the id table is swept once, one entry a cycle (ID_COUNT entries, capped at
// 1024 and rounded up to a power of two), and in_stall stays high throughout.
// An input word is taken only while the sequencer is idle. A lookup passes through
// S_LOOK, S_FETCH and S_CHK; each heap level visited by a sift passes through S_DOWN
// and S_DOWN_CMP, or S_UP and S_UP_CMP, because the compares work on registered reads
// of the heap memory. A tick removes every expired timer in turn, each with its own
// sift.
// Results sit in an output register; while out_stall is high the sequencer holds at its
// next result, and the next input word may still be taken once the sequencer is idle.
module min_heap_timer_queue #(
    parameter int CAPACITY  = 32,
    parameter int ID_COUNT  = 1024,
    parameter int TIME_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mhtq_pkg::KIND_W-1:0]    kind,
    input  logic [mhtq_pkg::ID_W-1:0]      timer_id,
    input  logic [mhtq_pkg::TMO_W-1:0]     timeout_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mhtq_pkg::RKIND_W-1:0]   result_kind,
    output logic [mhtq_pkg::ID_W-1:0]      fired_id,
    output logic [mhtq_pkg::STATUS_W-1:0]  status,
    output logic [mhtq_pkg::TMO_W-1:0]     remaining_ms,
    output logic                           none_pending,
    output logic                           last
);
    import mhtq_pkg::*;

    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IW         = SLOT_W + 1;
    localparam int HEAP_DEPTH = 1 << SLOT_W;
    localparam int TBL_DEPTH  = (ID_COUNT < 1024) ? ID_COUNT : 1024;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int TBL_SIZE   = 1 << TBL_AW;
    localparam int EW         = ID_W + TIME_BITS;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_FETCH, S_CHK, S_DOWN, S_DOWN_CMP, S_UP, S_UP_CMP,
        S_PLACE, S_REM_START, S_REM_LOAD, S_TICK_CHK, S_TICK_EVAL
    } state_t;

    logic [EW-1:0]     heap_mem [HEAP_DEPTH];
    logic [SLOT_W-1:0] tbl_mem  [TBL_SIZE];

    state_t              state_reg, state_next;
    logic [TBL_AW-1:0]   clr_reg, clr_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [TMO_W-1:0]    tmo_reg, tmo_next;
    logic [ID_W-1:0]     item_id_reg, item_id_next;
    logic [TIME_BITS-1:0] item_exp_reg, item_exp_next;
    logic [SLOT_W-1:0]   h_reg, h_next;
    logic [SLOT_W-1:0]   start_reg, start_next;
    logic [SLOT_W-1:0]   s_reg, s_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                ret_tick_reg, ret_tick_next;
    logic                out_valid_reg, out_valid_next;
    logic [RKIND_W-1:0]  rk_reg, rk_next;
    logic [ID_W-1:0]     fid_reg, fid_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [TMO_W-1:0]    rem_reg, rem_next;
    logic                none_reg, none_next;
    logic                last_reg, last_next;

    logic [SLOT_W-1:0] rd_a, rd_b, heap_wa;
    logic [EW-1:0]     rda, rdb, heap_wd;
    logic              heap_we;
    logic [TBL_AW-1:0] tbl_wa;
    logic [SLOT_W-1:0] tbl_wd, tbl_rd;
    logic              tbl_we;

    logic              emit_ok, emit;
    logic [RKIND_W-1:0] e_rk;
    logic [ID_W-1:0]   e_id;
    logic [STATUS_W-1:0] e_st;
    logic [TMO_W-1:0]  e_rem;
    logic              e_none, e_last;

    logic [IW-1:0]     c_idx, c1_idx, cnt_x;
    logic [SLOT_W-1:0] p_idx;
    logic [CNT_W-1:0]  nn;
    logic              in_range, known, right_sel, expired;
    logic [EW-1:0]     child;
    logic [SLOT_W-1:0] child_slot;
    logic [TIME_BITS-1:0] gap, add_exp;

    function automatic logic [TIME_BITS-1:0] key_of(input logic [TIME_BITS-1:0] e,
                                                    input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] d;
        d = e - now;
        return {~d[TIME_BITS-1], d[TIME_BITS-2:0]};
    endfunction

    function automatic logic [TBL_AW-1:0] tidx(input logic [ID_W-1:0] id);
        logic [ID_W+TBL_AW-1:0] w;
        w = {{TBL_AW{1'b0}}, id};
        return w[TBL_AW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        rda <= heap_mem[rd_a];
        rdb <= heap_mem[rd_b];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rd <= tbl_mem[tidx(id_reg)];
    end

    assign c_idx    = {h_reg, 1'b1};
    assign c1_idx   = c_idx + IW'(1);
    assign cnt_x    = IW'(count_reg);
    assign p_idx    = (h_reg - SLOT_W'(1)) >> 1;
    assign nn       = count_reg - CNT_W'(1);
    assign in_range = (32'(id_reg) < ID_COUNT);
    assign known    = in_range && (IW'(tbl_rd) < cnt_x) && (rda[EW-1:TIME_BITS] == id_reg);
    assign right_sel = (c1_idx < cnt_x) &&
                       (key_of(rdb[TIME_BITS-1:0], now_reg) < key_of(rda[TIME_BITS-1:0], now_reg));
    assign child      = right_sel ? rdb : rda;
    assign child_slot = right_sel ? c1_idx[SLOT_W-1:0] : c_idx[SLOT_W-1:0];
    assign gap        = rda[TIME_BITS-1:0] - now_reg;
    assign expired    = (gap == '0) || gap[TIME_BITS-1];
    assign add_exp    = now_reg + TIME_BITS'(tmo_reg);
    assign emit_ok    = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        tmo_next      = tmo_reg;
        item_id_next  = item_id_reg;
        item_exp_next = item_exp_reg;
        h_next        = h_reg;
        start_next    = start_reg;
        s_next        = s_reg;
        count_next    = count_reg;
        now_next      = now_reg;
        ret_tick_next = ret_tick_reg;
        rd_a    = '0;
        rd_b    = '0;
        heap_we = 1'b0;
        heap_wa = h_reg;
        heap_wd = child;
        tbl_we  = 1'b0;
        tbl_wa  = tidx(child[EW-1:TIME_BITS]);
        tbl_wd  = h_reg;
        emit    = 1'b0;
        e_rk    = RES_ACK;
        e_id    = id_reg;
        e_st    = ST_OK;
        e_rem   = '0;
        e_none  = 1'b0;
        e_last  = 1'b1;

        case (state_reg)
            S_CLR:
            begin
                tbl_we   = 1'b1;
                tbl_wa   = clr_reg;
                tbl_wd   = '0;
                clr_next = clr_reg + TBL_AW'(1);
                if (clr_reg == TBL_AW'(TBL_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    id_next   = timer_id;
                    tmo_next  = timeout_ms;
                    if (kind <= KIND_TICK)
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                state_next = S_FETCH;
            end
            S_FETCH, S_CHK:
            begin
                rd_a = (kind_reg == KIND_POP) ? '0 : tbl_rd;
                if (state_reg == S_FETCH)
                begin
                    state_next = S_CHK;
                end
                else if (emit_ok)
                begin
                    ret_tick_next = 1'b0;
                    state_next    = S_IDLE;
                    case (kind_reg)
                        KIND_ADD, KIND_ADJUST:
                        begin
                            emit          = 1'b1;
                            item_id_next  = id_reg;
                            item_exp_next = add_exp;
                            if (known)
                            begin
                                h_next     = tbl_rd;
                                start_next = tbl_rd;
                                state_next = S_DOWN;
                            end
                            else if (!in_range || kind_reg == KIND_ADJUST)
                            begin
                                e_st = ST_UNKNOWN;
                            end
                            else if (32'(count_reg) >= CAPACITY)
                            begin
                                e_st = ST_FULL;
                            end
                            else
                            begin
                                h_next     = count_reg[SLOT_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                state_next = S_UP;
                            end
                        end
                        KIND_FIRE:
                        begin
                            emit = 1'b1;
                            if (known)
                            begin
                                e_rk       = RES_FIRED;
                                s_next     = tbl_rd;
                                state_next = S_REM_START;
                            end
                            else
                            begin
                                e_st = ST_UNKNOWN;
                            end
                        end
                        KIND_POP:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                            begin
                                e_id = '0;
                                e_st = ST_EMPTY;
                            end
                            else
                            begin
                                e_id       = rda[EW-1:TIME_BITS];
                                s_next     = '0;
                                state_next = S_REM_START;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            emit       = 1'b1;
                            e_id       = '0;
                            count_next = '0;
                        end
                        KIND_TICK:
                        begin
                            now_next   = now_reg + TIME_BITS'(1);
                            state_next = S_TICK_CHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TICK_CHK, S_TICK_EVAL:
            begin
                rd_a = '0;
                if (state_reg == S_TICK_CHK && count_reg != '0)
                begin
                    state_next = S_TICK_EVAL;
                end
                else if (emit_ok)
                begin
                    emit       = 1'b1;
                    e_id       = '0;
                    state_next = S_IDLE;
                    if (state_reg == S_TICK_CHK)
                    begin
                        e_rk   = RES_REPORT;
                        e_none = 1'b1;
                    end
                    else if (expired)
                    begin
                        e_rk          = RES_FIRED;
                        e_id          = rda[EW-1:TIME_BITS];
                        e_last        = 1'b0;
                        s_next        = '0;
                        ret_tick_next = 1'b1;
                        state_next    = S_REM_START;
                    end
                    else
                    begin
                        e_rk  = RES_REPORT;
                        e_rem = (gap > TIME_BITS'(REM_MAX)) ? REM_MAX : gap[TMO_W-1:0];
                    end
                end
            end
            S_REM_START, S_REM_LOAD:
            begin
                rd_a = nn[SLOT_W-1:0];
                if (state_reg == S_REM_LOAD)
                begin
                    item_id_next  = rda[EW-1:TIME_BITS];
                    item_exp_next = rda[TIME_BITS-1:0];
                    count_next    = nn;
                    h_next        = s_reg;
                    start_next    = s_reg;
                    state_next    = S_DOWN;
                end
                else if (IW'(s_reg) < IW'(nn))
                begin
                    state_next = S_REM_LOAD;
                end
                else
                begin
                    count_next = nn;
                    state_next = ret_tick_reg ? S_TICK_CHK : S_IDLE;
                end
            end
            S_DOWN, S_DOWN_CMP:
            begin
                rd_a = c_idx[SLOT_W-1:0];
                rd_b = c1_idx[SLOT_W-1:0];
                if (state_reg == S_DOWN)
                begin
                    if (c_idx >= cnt_x)
                    begin
                        state_next = (h_reg != start_reg) ? S_PLACE : S_UP;
                    end
                    else
                    begin
                        state_next = S_DOWN_CMP;
                    end
                end
                else if (key_of(item_exp_reg, now_reg) < key_of(child[TIME_BITS-1:0], now_reg))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    heap_we    = 1'b1;
                    tbl_we     = 1'b1;
                    h_next     = child_slot;
                    state_next = S_DOWN;
                end
            end
            S_UP, S_UP_CMP:
            begin
                rd_a = p_idx;
                if (state_reg == S_UP)
                begin
                    state_next = (h_reg == '0) ? S_PLACE : S_UP_CMP;
                end
                else if (key_of(rda[TIME_BITS-1:0], now_reg) < key_of(item_exp_reg, now_reg))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wd    = rda;
                    tbl_we     = 1'b1;
                    tbl_wa     = tidx(rda[EW-1:TIME_BITS]);
                    h_next     = p_idx;
                    state_next = S_UP;
                end
            end
            S_PLACE:
            begin
                heap_we    = 1'b1;
                heap_wd    = {item_id_reg, item_exp_reg};
                tbl_we     = 1'b1;
                tbl_wa     = tidx(item_id_reg);
                state_next = ret_tick_reg ? S_TICK_CHK : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && out_stall);
        rk_next   = emit ? e_rk : rk_reg;
        fid_next  = emit ? e_id : fid_reg;
        st_next   = emit ? e_st : st_reg;
        rem_next  = emit ? e_rem : rem_reg;
        none_next = emit ? e_none : none_reg;
        last_next = emit ? e_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            count_reg     <= '0;
            now_reg       <= '0;
            ret_tick_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            ret_tick_reg  <= ret_tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        tmo_reg      <= tmo_next;
        item_id_reg  <= item_id_next;
        item_exp_reg <= item_exp_next;
        h_reg        <= h_next;
        start_reg    <= start_next;
        s_reg        <= s_next;
        rk_reg       <= rk_next;
        fid_reg      <= fid_next;
        st_reg       <= st_next;
        rem_reg      <= rem_next;
        none_reg     <= none_next;
        last_reg     <= last_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_kind  = rk_reg;
    assign fired_id     = fid_reg;
    assign status       = st_reg;
    assign remaining_ms = rem_reg;
    assign none_pending = none_reg;
    assign last         = last_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, 32'(count_reg) <= CAPACITY)
    `ASSERT_IMPLIES(a_child_in_heap, clk, rst_n, state_reg == S_DOWN_CMP, c_idx < cnt_x)
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall && kind <= KIND_TICK, state_reg == S_LOOK)

endmodule
